>>> hw/rtl/acn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acn_pkg
// Shared types, codes and helpers for the box pair collide and nudge block.
// ----------------------------------------------------------------------------
package acn_pkg;

    localparam int SLOTS_DEF  = 64;
    localparam int COORD_BITS = 24;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int FRAC_BITS  = 8;
    localparam int SLOT_BITS  = 6;
    localparam int EDGE_W     = COORD_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [SIZE_BITS-1:0]         size_t;
    typedef logic signed [EDGE_W-1:0]     edge_t;
    typedef logic [SLOT_BITS-1:0]         slot_t;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_PAIR  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CB_NONE   = 2'd0,
        CB_FIRST  = 2'd1,
        CB_SECOND = 2'd2,
        CB_UNUSED = 2'd3
    } cb_order_t;

    localparam logic signed [COORD_BITS:0] UNIT_EXT = (COORD_BITS + 1)'(1 << FRAC_BITS);

    typedef struct packed {
        logic [1:0] action;
        slot_t      slot;
        slot_t      other_slot;
        coord_t     pos_x;
        coord_t     pos_y;
        size_t      size_w;
        size_t      size_h;
        logic       has_box;
        logic       has_physics;
        logic       has_script;
    } req_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] callback_order;
        coord_t     read_x;
        coord_t     read_y;
    } rsp_t;

    typedef struct packed {
        logic script;
        logic phys;
        logic box;
    } flags_t;

    typedef struct packed {
        coord_t cx;
        coord_t cy;
        size_t  w;
        size_t  h;
    } entry_t;

    typedef struct packed {
        logic accept;
        logic edges;
        logic compare;
        logic nudge_i;
        logic nudge_j;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic pair_ok;
    } status_t;

    // 2*c - s and 2*c + s at doubled scale
    function automatic edge_t edge_lo(coord_t c, size_t s);
        return $signed({c[COORD_BITS-1], c, 1'b0}) - $signed({3'b000, s});
    endfunction

    function automatic edge_t edge_hi(coord_t c, size_t s);
        return $signed({c[COORD_BITS-1], c, 1'b0}) + $signed({3'b000, s});
    endfunction

    // one unit step with saturation to the coordinate range
    function automatic coord_t nudge(coord_t p, logic down);
        logic signed [COORD_BITS:0] r;
        r = down ? ($signed({p[COORD_BITS-1], p}) - UNIT_EXT)
                 : ($signed({p[COORD_BITS-1], p}) + UNIT_EXT);
        if (r[COORD_BITS] != r[COORD_BITS-1])
        begin
            return r[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                 : {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        return r[COORD_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/acn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acn_ctrl
// Sequencer: accepts a request, steps the datapath, owns the response valid.
// ----------------------------------------------------------------------------
module acn_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic [1:0]      req_action,
    output logic            req_stall,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    input  acn_pkg::status_t status,
    output acn_pkg::cmd_t   cmd
);
    import acn_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EDGE    = 7'b0000010,
        S_CMP     = 7'b0000100,
        S_NUDGE_I = 7'b0001000,
        S_NUDGE_J = 7'b0010000,
        S_DONE    = 7'b0100000,
        S_SPARE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (req_action == ACT_PAIR) ? S_EDGE : S_DONE;
                end
            end
            S_EDGE:
            begin
                cmd.edges  = 1'b1;
                state_next = status.pair_ok ? S_CMP : S_DONE;
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_NUDGE_I;
            end
            S_NUDGE_I:
            begin
                cmd.nudge_i = 1'b1;
                state_next  = S_NUDGE_J;
            end
            S_NUDGE_J:
            begin
                cmd.nudge_j = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hw/rtl/acn_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acn_dp
// Datapath: slot table, flags, edge compare, nudge and response register.
// ----------------------------------------------------------------------------
module acn_dp #(
    parameter int SLOTS = acn_pkg::SLOTS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  acn_pkg::req_t    req,
    input  acn_pkg::cmd_t    cmd,
    output acn_pkg::status_t status,
    output acn_pkg::rsp_t    rsp
);
    import acn_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    entry_t mem [SLOTS];
    flags_t flag_reg [SLOTS];

    entry_t ra_reg, rb_reg;
    flags_t fa_reg, fb_reg;
    logic [1:0] act_reg;
    logic [IDX_W-1:0] ia_reg, ib_reg;
    logic ok_reg, rd_ok_reg;
    logic hit_reg;
    logic [1:0] order_reg;
    edge_t al_reg, ar_reg, at_reg, ab_reg, bl_reg, br_reg, bt_reg, bb_reg;
    coord_t nax_reg, nay_reg;
    rsp_t rsp_reg, rsp_next;

    logic [IDX_W-1:0] idx_a, idx_b;
    logic in_a, in_b;
    flags_t fa_in, fb_in;

    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t mem_wdata;
    logic wr_slot;

    coord_t nax, nay, nbx, nby;
    logic move_a, move_b;

    assign idx_a = IDX_W'(req.slot);
    assign idx_b = IDX_W'(req.other_slot);
    assign in_a  = (32'(req.slot) < SLOTS);
    assign in_b  = (32'(req.other_slot) < SLOTS);
    assign fa_in = in_a ? flag_reg[idx_a] : '0;
    assign fb_in = in_b ? flag_reg[idx_b] : '0;
    assign wr_slot = cmd.accept && (req.action == ACT_WRITE) && in_a;

    assign move_a = hit_reg && fa_reg.phys;
    assign move_b = hit_reg && fb_reg.phys;

    always_comb
    begin
        nax = move_a ? nudge(ra_reg.cx, ra_reg.cx < rb_reg.cx) : ra_reg.cx;
        nay = move_a ? nudge(ra_reg.cy, ra_reg.cy < rb_reg.cy) : ra_reg.cy;
        nbx = nudge(rb_reg.cx, rb_reg.cx < nax_reg);
        nby = nudge(rb_reg.cy, rb_reg.cy < nay_reg);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_a;
        mem_wdata = '{cx: req.pos_x, cy: req.pos_y, w: req.size_w, h: req.size_h};
        if (wr_slot)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.nudge_i)
        begin
            mem_we    = move_a;
            mem_waddr = ia_reg;
            mem_wdata = '{cx: nax, cy: nay, w: ra_reg.w, h: ra_reg.h};
        end
        else if (cmd.nudge_j)
        begin
            mem_we    = move_b;
            mem_waddr = ib_reg;
            mem_wdata = '{cx: nbx, cy: nby, w: rb_reg.w, h: rb_reg.h};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept)
        begin
            ra_reg <= mem[idx_a];
            rb_reg <= mem[idx_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                flag_reg[k] <= '0;
            end
        end
        else if (wr_slot)
        begin
            flag_reg[idx_a] <= '{script: req.has_script, phys: req.has_physics,
                                 box: req.has_box};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg   <= req.action;
            ia_reg    <= idx_a;
            ib_reg    <= idx_b;
            fa_reg    <= fa_in;
            fb_reg    <= fb_in;
            rd_ok_reg <= in_a;
            ok_reg    <= (req.action == ACT_PAIR) && in_a && in_b &&
                         (req.slot != req.other_slot) && fa_in.box && fb_in.box;
            hit_reg   <= 1'b0;
            order_reg <= CB_NONE;
        end
        if (cmd.edges)
        begin
            al_reg <= edge_lo(ra_reg.cx, ra_reg.w);
            ar_reg <= edge_hi(ra_reg.cx, ra_reg.w);
            ab_reg <= edge_lo(ra_reg.cy, ra_reg.h);
            at_reg <= edge_hi(ra_reg.cy, ra_reg.h);
            bl_reg <= edge_lo(rb_reg.cx, rb_reg.w);
            br_reg <= edge_hi(rb_reg.cx, rb_reg.w);
            bb_reg <= edge_lo(rb_reg.cy, rb_reg.h);
            bt_reg <= edge_hi(rb_reg.cy, rb_reg.h);
        end
        if (cmd.compare)
        begin
            hit_reg <= ok_reg && (al_reg < br_reg) && (ar_reg > bl_reg) &&
                       (at_reg > bb_reg) && (ab_reg < bt_reg);
            if (!(ok_reg && (al_reg < br_reg) && (ar_reg > bl_reg) &&
                  (at_reg > bb_reg) && (ab_reg < bt_reg)))
            begin
                order_reg <= CB_NONE;
            end
            else if (fa_reg.script)
            begin
                order_reg <= CB_FIRST;
            end
            else if (fb_reg.script)
            begin
                order_reg <= CB_SECOND;
            end
            else
            begin
                order_reg <= CB_NONE;
            end
        end
        if (cmd.nudge_i)
        begin
            nax_reg <= nax;
            nay_reg <= nay;
        end
        if (cmd.load_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_comb
    begin
        rsp_next = '0;
        case (act_reg)
            ACT_PAIR:
            begin
                rsp_next.hit            = hit_reg;
                rsp_next.callback_order = order_reg;
            end
            ACT_READ:
            begin
                if (rd_ok_reg)
                begin
                    rsp_next.read_x = ra_reg.cx;
                    rsp_next.read_y = ra_reg.cy;
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    assign status.pair_ok = ok_reg;
    assign rsp            = rsp_reg;

endmodule

>>> hw/rtl/aabb_pair_collide_nudge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_pair_collide_nudge
// Slot table of 2D boxes with pair overlap test and one-unit separation nudge.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one request: write a
//   slot, test a pair of slots, or read a slot centre. rsp channel
//   (rsp_valid / rsp_stall / rsp) returns exactly one response per request.
//   One request is in flight at a time; req_stall is high while it is worked.
//   Write, read and unused actions: accept, then response load.
//   Skipped pair tests (same, absent or out-of-range slot): edge build, load.
//   Pair tests on two present, distinct slots: edge build, compare, nudge
//   of the first slot, nudge of the second slot, response load; the two
//   nudges are apart as the slot memory has a single write port, which
//   takes one write-back a cycle.
//   The next request is taken the cycle after the response loads.
//   A finished response waits in the output register; the next request is
//   still accepted, and its result is held back until rsp_stall drops.
//   Reset clears all slot flags (every slot absent) and empties the output.
//   Box centres and sizes are not cleared; a slot must be written before use.
// ----------------------------------------------------------------------------
module aabb_pair_collide_nudge #(
    parameter int SLOTS = acn_pkg::SLOTS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  acn_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output acn_pkg::rsp_t rsp
);
    import acn_pkg::*;

    cmd_t    cmd;
    status_t status;

    acn_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req.action),
        .req_stall  (req_stall),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .cmd        (cmd)
    );

    acn_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule
